/* src/look_at_view_basis_top_macros.svh */
// assertion macros for the look-at view basis block
// used by the checker module, relies on clk_i and rst_ni in the including scope
`ifndef LOOK_AT_VIEW_BASIS_TOP_MACROS_SVH
`define LOOK_AT_VIEW_BASIS_TOP_MACROS_SVH

// same-cycle implication
`define LAVB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication after a fixed number of cycles
`define LAVB_ASSERT_LATER(label, ante, n, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

/* src/lavb_pkg.sv */
// shared types and constants of the look-at view basis pipeline
// no dependencies
package lavb_pkg;

  localparam int FRAC_BITS = 16;
  localparam int OUT_W     = 18;
  localparam int UNIT_W    = FRAC_BITS + 2;
  localparam int UP_W      = 32;
  localparam int PROD_W    = UP_W + UNIT_W;
  localparam int IN_W      = PROD_W + 1;
  localparam int POS_W     = $clog2(IN_W);
  localparam int NRM_W     = 30;
  localparam int SQR_W     = 2 * NRM_W;
  localparam int SUM_W     = SQR_W + 2;
  localparam int SQ_N      = SUM_W / 2;
  localparam int ROOT_W    = SQ_N;
  localparam int REM_W     = ROOT_W + 3;
  localparam int DIV_N     = FRAC_BITS + 1;
  localparam int NUM_W     = NRM_W + FRAC_BITS + 1;

  localparam int NORM_LAT  = 7 + SQ_N + DIV_N;
  localparam int CROSS_LAT = 2;
  localparam int LATENCY   = 3 * NORM_LAT + 2 * CROSS_LAT + 2;

  typedef struct packed {
    logic [2:0][UP_W-1:0]   up;
    logic [2:0][UNIT_W-1:0] fwd;
    logic [2:0][UNIT_W-1:0] rt;
    logic                   degen;
  } lavb_side_t;

  function automatic logic [OUT_W-1:0] to_out(input logic [UNIT_W-1:0] v);
    logic signed [UNIT_W-1:0] s;
    s = $signed(v);
    return OUT_W'(s);
  endfunction

endpackage

/* src/lavb_norm.sv */
// pipelined vector normalizer: scale, sum of squares, digit-serial sqrt, divide
// depends on lavb_pkg
module lavb_norm import lavb_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [2:0][IN_W-1:0]         vec_i,
  input  lavb_side_t                   side_i,
  output logic                         valid_o,
  output logic [2:0][UNIT_W-1:0]       unit_o,
  output logic                         zero_o,
  output lavb_side_t                   side_o
);

  typedef struct packed {
    logic [2:0][NRM_W-1:0] mag;
    logic [2:0]            neg;
    logic                  zero;
    lavb_side_t            side;
  } nrm_dat_t;

  // sign and magnitude
  logic                  a_vld_q;
  logic [2:0][IN_W-1:0]  a_mag_q;
  logic [2:0]            a_neg_q;
  lavb_side_t            a_side_q;
  // largest magnitude position
  logic                  b_vld_q;
  logic [2:0][IN_W-1:0]  b_mag_q;
  logic [2:0]            b_neg_q;
  logic                  b_zero_q;
  logic [POS_W-1:0]      b_pos_q;
  lavb_side_t            b_side_q;
  // scaled magnitudes
  logic                  c_vld_q;
  nrm_dat_t              c_dat_q;
  // squares
  logic                  d_vld_q;
  nrm_dat_t              d_dat_q;
  logic [2:0][SQR_W-1:0] d_sq_q;
  // square root stages, index 0 holds the sum
  logic                  sq_vld_q  [SQ_N+1];
  nrm_dat_t              sq_dat_q  [SQ_N+1];
  logic [SUM_W-1:0]      sq_s_q    [SQ_N+1];
  logic [REM_W-1:0]      sq_rem_q  [SQ_N+1];
  logic [ROOT_W-1:0]     sq_root_q [SQ_N+1];
  logic [REM_W-1:0]      sq_rem_d  [SQ_N];
  logic [ROOT_W-1:0]     sq_root_d [SQ_N];
  // divider stages, index 0 holds the prepared dividend
  logic                      dv_vld_q [DIV_N+1];
  nrm_dat_t                  dv_dat_q [DIV_N+1];
  logic [ROOT_W-1:0]         dv_len_q [DIV_N+1];
  logic [2:0][NUM_W-1:0]     dv_num_q [DIV_N+1];
  logic [2:0][ROOT_W-1:0]    dv_r_q   [DIV_N+1];
  logic [2:0][DIV_N-1:0]     dv_quo_q [DIV_N+1];
  logic [2:0][ROOT_W-1:0]    dv_r_d   [DIV_N];
  logic [2:0][DIV_N-1:0]     dv_quo_d [DIV_N];

  logic [IN_W-1:0]      m_max;
  logic [POS_W-1:0]     m_pos;
  logic [2:0][NRM_W-1:0] c_mag_d;
  logic [2:0][NUM_W-1:0] p_num_d;
  logic [2:0][UNIT_W-1:0] unit_d;

  always_comb begin
    m_max = '0;
    m_pos = '0;
    for (int c = 0; c < 3; c++) begin
      if (a_mag_q[c] > m_max) m_max = a_mag_q[c];
    end
    for (int b = 0; b < IN_W; b++) begin
      if (m_max[b]) m_pos = POS_W'(b);
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (b_pos_q >= POS_W'(NRM_W - 1)) begin
        c_mag_d[c] = NRM_W'(b_mag_q[c] >> (b_pos_q - POS_W'(NRM_W - 1)));
      end else begin
        c_mag_d[c] = NRM_W'(b_mag_q[c] << (POS_W'(NRM_W - 1) - b_pos_q));
      end
    end
  end

  // one root bit per stage
  always_comb begin
    logic [REM_W-1:0] rn;
    logic [REM_W-1:0] trial;
    for (int k = 0; k < SQ_N; k++) begin
      rn    = {sq_rem_q[k][REM_W-3:0], sq_s_q[k][2*(SQ_N-1-k) +: 2]};
      trial = REM_W'({sq_root_q[k], 2'b01});
      if (rn >= trial) begin
        sq_rem_d[k]  = rn - trial;
        sq_root_d[k] = {sq_root_q[k][ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem_d[k]  = rn;
        sq_root_d[k] = {sq_root_q[k][ROOT_W-2:0], 1'b0};
      end
    end
  end

  // rounded dividend: mag * 2^frac + len / 2
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      p_num_d[c] = NUM_W'({sq_dat_q[SQ_N].mag[c], {FRAC_BITS{1'b0}}})
                 + NUM_W'(sq_root_q[SQ_N] >> 1);
    end
  end

  // one quotient bit per stage and lane
  always_comb begin
    logic [ROOT_W:0] r2;
    for (int k = 0; k < DIV_N; k++) begin
      for (int c = 0; c < 3; c++) begin
        r2 = {dv_r_q[k][c], dv_num_q[k][c][DIV_N-1-k]};
        dv_quo_d[k][c] = dv_quo_q[k][c];
        if (r2 >= {1'b0, dv_len_q[k]}) begin
          dv_r_d[k][c] = ROOT_W'(r2 - {1'b0, dv_len_q[k]});
          dv_quo_d[k][c][DIV_N-1-k] = 1'b1;
        end else begin
          dv_r_d[k][c] = ROOT_W'(r2);
        end
      end
    end
  end

  always_comb begin
    logic [DIV_N-1:0]  q;
    logic [UNIT_W-1:0] qu;
    for (int c = 0; c < 3; c++) begin
      q = dv_quo_q[DIV_N][c];
      if (q > {1'b1, {FRAC_BITS{1'b0}}}) q = {1'b1, {FRAC_BITS{1'b0}}};
      qu = UNIT_W'(q);
      if (dv_dat_q[DIV_N].zero) begin
        unit_d[c] = '0;
      end else if (dv_dat_q[DIV_N].neg[c]) begin
        unit_d[c] = -qu;
      end else begin
        unit_d[c] = qu;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      for (int k = 0; k <= SQ_N; k++) sq_vld_q[k] <= 1'b0;
      for (int k = 0; k <= DIV_N; k++) dv_vld_q[k] <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      a_vld_q     <= valid_i;
      b_vld_q     <= a_vld_q;
      c_vld_q     <= b_vld_q;
      d_vld_q     <= c_vld_q;
      sq_vld_q[0] <= d_vld_q;
      for (int k = 0; k < SQ_N; k++) sq_vld_q[k+1] <= sq_vld_q[k];
      dv_vld_q[0] <= sq_vld_q[SQ_N];
      for (int k = 0; k < DIV_N; k++) dv_vld_q[k+1] <= dv_vld_q[k];
      valid_o     <= dv_vld_q[DIV_N];
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      a_neg_q[c] <= vec_i[c][IN_W-1];
      a_mag_q[c] <= vec_i[c][IN_W-1] ? -vec_i[c] : vec_i[c];
    end
    a_side_q <= side_i;

    b_mag_q  <= a_mag_q;
    b_neg_q  <= a_neg_q;
    b_zero_q <= (m_max == '0);
    b_pos_q  <= m_pos;
    b_side_q <= a_side_q;

    c_dat_q.mag  <= c_mag_d;
    c_dat_q.neg  <= b_neg_q;
    c_dat_q.zero <= b_zero_q;
    c_dat_q.side <= b_side_q;

    d_dat_q <= c_dat_q;
    for (int c = 0; c < 3; c++) begin
      d_sq_q[c] <= SQR_W'(c_dat_q.mag[c]) * SQR_W'(c_dat_q.mag[c]);
    end

    sq_dat_q[0]  <= d_dat_q;
    sq_s_q[0]    <= SUM_W'(d_sq_q[0]) + SUM_W'(d_sq_q[1]) + SUM_W'(d_sq_q[2]);
    sq_rem_q[0]  <= '0;
    sq_root_q[0] <= '0;
    for (int k = 0; k < SQ_N; k++) begin
      sq_dat_q[k+1]  <= sq_dat_q[k];
      sq_s_q[k+1]    <= sq_s_q[k];
      sq_rem_q[k+1]  <= sq_rem_d[k];
      sq_root_q[k+1] <= sq_root_d[k];
    end

    dv_dat_q[0] <= sq_dat_q[SQ_N];
    dv_len_q[0] <= sq_root_q[SQ_N];
    dv_num_q[0] <= p_num_d;
    for (int c = 0; c < 3; c++) begin
      dv_r_q[0][c] <= ROOT_W'(p_num_d[c][NUM_W-1:DIV_N]);
    end
    dv_quo_q[0] <= '0;
    for (int k = 0; k < DIV_N; k++) begin
      dv_dat_q[k+1] <= dv_dat_q[k];
      dv_len_q[k+1] <= dv_len_q[k];
      dv_num_q[k+1] <= dv_num_q[k];
      dv_r_q[k+1]   <= dv_r_d[k];
      dv_quo_q[k+1] <= dv_quo_d[k];
    end

    unit_o <= unit_d;
    zero_o <= dv_dat_q[DIV_N].zero;
    side_o <= dv_dat_q[DIV_N].side;
  end

endmodule

/* src/lavb_cross.sv */
// two-stage cross product a x b with side data carried along
// depends on lavb_pkg
module lavb_cross import lavb_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [2:0][UP_W-1:0]   a_i,
  input  logic [2:0][UNIT_W-1:0] b_i,
  input  lavb_side_t             side_i,
  output logic                   valid_o,
  output logic [2:0][IN_W-1:0]   vec_o,
  output lavb_side_t             side_o
);

  logic                     p_vld_q;
  logic signed [PROD_W-1:0] p_q [6];
  lavb_side_t               p_side_q;
  logic signed [PROD_W-1:0] p_d [6];

  // products in order a1b2 a2b1 a2b0 a0b2 a0b1 a1b0
  assign p_d[0] = $signed(a_i[1]) * $signed(b_i[2]);
  assign p_d[1] = $signed(a_i[2]) * $signed(b_i[1]);
  assign p_d[2] = $signed(a_i[2]) * $signed(b_i[0]);
  assign p_d[3] = $signed(a_i[0]) * $signed(b_i[2]);
  assign p_d[4] = $signed(a_i[0]) * $signed(b_i[1]);
  assign p_d[5] = $signed(a_i[1]) * $signed(b_i[0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      p_vld_q <= valid_i;
      valid_o <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 6; i++) p_q[i] <= p_d[i];
    p_side_q <= side_i;
    for (int c = 0; c < 3; c++) begin
      vec_o[c] <= IN_W'(p_q[2*c]) - IN_W'(p_q[2*c+1]);
    end
    side_o <= p_side_q;
  end

endmodule

/* src/look_at_view_basis_top.sv */
// look-at view basis: top level of the camera basis pipeline
// depends on lavb_pkg, lavb_norm and lavb_cross
//
// A fully pipelined unit that turns a target point, an eye point and an up
// reference (signed Q16.16) into the camera basis forward, right and true up
// (signed Q1.16). One item is taken in every clock cycle: busy is always low
// and an item is accepted whenever start is high. The result of each item
// is on the output ports for exactly one cycle, marked by done_o.
// The pipeline holds three normalizer units in series, each with a one bit
// per stage square root (31 stages) and a one bit per stage divider
// (frac + 1 stages), with a cross product unit between each pair. The receiver
// cannot stall the pipeline, so results must be taken as they come.
// degenerate_o flags that some axis had zero length and was output as zero.
module look_at_view_basis_top import lavb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [31:0]      target_x_i,
  input  logic signed [31:0]      target_y_i,
  input  logic signed [31:0]      target_z_i,
  input  logic signed [31:0]      eye_x_i,
  input  logic signed [31:0]      eye_y_i,
  input  logic signed [31:0]      eye_z_i,
  input  logic signed [31:0]      upref_x_i,
  input  logic signed [31:0]      upref_y_i,
  input  logic signed [31:0]      upref_z_i,
  output logic                    done_o,
  output logic signed [OUT_W-1:0] right_x_o,
  output logic signed [OUT_W-1:0] right_y_o,
  output logic signed [OUT_W-1:0] right_z_o,
  output logic signed [OUT_W-1:0] trueup_x_o,
  output logic signed [OUT_W-1:0] trueup_y_o,
  output logic signed [OUT_W-1:0] trueup_z_o,
  output logic signed [OUT_W-1:0] forward_x_o,
  output logic signed [OUT_W-1:0] forward_y_o,
  output logic signed [OUT_W-1:0] forward_z_o,
  output logic                    degenerate_o
);

  // no backpressure anywhere: an item enters every cycle
  assign busy = 1'b0;

  // input stage: eye to target difference
  logic                 in_vld_q;
  logic [2:0][IN_W-1:0] in_dir_q;
  lavb_side_t           in_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    in_dir_q[0] <= IN_W'(target_x_i) - IN_W'(eye_x_i);
    in_dir_q[1] <= IN_W'(target_y_i) - IN_W'(eye_y_i);
    in_dir_q[2] <= IN_W'(target_z_i) - IN_W'(eye_z_i);
    in_side_q.up    <= {upref_z_i, upref_y_i, upref_x_i};
    in_side_q.fwd   <= '0;
    in_side_q.rt    <= '0;
    in_side_q.degen <= 1'b0;
  end

  // forward axis
  logic                   n1_vld;
  logic [2:0][UNIT_W-1:0] n1_unit;
  logic                   n1_zero;
  lavb_side_t             n1_side;
  lavb_side_t             x1_side_in;

  lavb_norm u_norm_fwd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_vld_q),
    .vec_i   (in_dir_q),
    .side_i  (in_side_q),
    .valid_o (n1_vld),
    .unit_o  (n1_unit),
    .zero_o  (n1_zero),
    .side_o  (n1_side)
  );

  always_comb begin
    x1_side_in       = n1_side;
    x1_side_in.fwd   = n1_unit;
    x1_side_in.degen = n1_zero;
  end

  // right axis: up reference cross forward
  logic                 x1_vld;
  logic [2:0][IN_W-1:0] x1_vec;
  lavb_side_t           x1_side;

  lavb_cross u_cross_rt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (n1_vld),
    .a_i     (n1_side.up),
    .b_i     (n1_unit),
    .side_i  (x1_side_in),
    .valid_o (x1_vld),
    .vec_o   (x1_vec),
    .side_o  (x1_side)
  );

  logic                   n2_vld;
  logic [2:0][UNIT_W-1:0] n2_unit;
  logic                   n2_zero;
  lavb_side_t             n2_side;
  lavb_side_t             x2_side_in;
  logic [2:0][UP_W-1:0]   x2_a;

  lavb_norm u_norm_rt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (x1_vld),
    .vec_i   (x1_vec),
    .side_i  (x1_side),
    .valid_o (n2_vld),
    .unit_o  (n2_unit),
    .zero_o  (n2_zero),
    .side_o  (n2_side)
  );

  always_comb begin
    x2_side_in       = n2_side;
    x2_side_in.rt    = n2_unit;
    x2_side_in.degen = n2_side.degen | n2_zero;
    // forward sign-extended into the wide operand
    for (int c = 0; c < 3; c++) begin
      x2_a[c] = UP_W'($signed(n2_side.fwd[c]));
    end
  end

  // true up axis: forward cross right
  logic                 x2_vld;
  logic [2:0][IN_W-1:0] x2_vec;
  lavb_side_t           x2_side;

  lavb_cross u_cross_tu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (n2_vld),
    .a_i     (x2_a),
    .b_i     (n2_unit),
    .side_i  (x2_side_in),
    .valid_o (x2_vld),
    .vec_o   (x2_vec),
    .side_o  (x2_side)
  );

  logic                   n3_vld;
  logic [2:0][UNIT_W-1:0] n3_unit;
  logic                   n3_zero;
  lavb_side_t             n3_side;

  lavb_norm u_norm_tu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (x2_vld),
    .vec_i   (x2_vec),
    .side_i  (x2_side),
    .valid_o (n3_vld),
    .unit_o  (n3_unit),
    .zero_o  (n3_zero),
    .side_o  (n3_side)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= n3_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    right_x_o    <= to_out(n3_side.rt[0]);
    right_y_o    <= to_out(n3_side.rt[1]);
    right_z_o    <= to_out(n3_side.rt[2]);
    trueup_x_o   <= to_out(n3_unit[0]);
    trueup_y_o   <= to_out(n3_unit[1]);
    trueup_z_o   <= to_out(n3_unit[2]);
    forward_x_o  <= to_out(n3_side.fwd[0]);
    forward_y_o  <= to_out(n3_side.fwd[1]);
    forward_z_o  <= to_out(n3_side.fwd[2]);
    degenerate_o <= n3_side.degen | n3_zero;
  end

endmodule

/* src/lavb_checker.sv */
// port-level checks of the look-at view basis block, bound to the top level
// depends on lavb_pkg and look_at_view_basis_top_macros.svh
`include "look_at_view_basis_top_macros.svh"

module lavb_checker import lavb_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start,
  input logic                    busy,
  input logic                    done_o,
  input logic signed [OUT_W-1:0] right_x_o,
  input logic signed [OUT_W-1:0] right_y_o,
  input logic signed [OUT_W-1:0] right_z_o,
  input logic signed [OUT_W-1:0] forward_x_o,
  input logic signed [OUT_W-1:0] forward_y_o,
  input logic signed [OUT_W-1:0] forward_z_o,
  input logic                    degenerate_o
);

  logic fwd_zero;
  logic rt_zero;

  assign fwd_zero = (forward_x_o == '0) && (forward_y_o == '0) && (forward_z_o == '0);
  assign rt_zero  = (right_x_o == '0) && (right_y_o == '0) && (right_z_o == '0);

  // every accepted item comes out after the pipeline latency
  `LAVB_ASSERT_LATER(a_item_out, start && !busy, LATENCY, done_o, "item lost in pipeline")
  // no result without an item accepted that long before
  `LAVB_ASSERT_NOW(a_no_spurious, done_o, $past(start && !busy, LATENCY), "spurious result")
  // a zero forward or right axis only with the flag raised
  `LAVB_ASSERT_NOW(a_fwd_flag, done_o && fwd_zero, degenerate_o, "zero forward unflagged")
  `LAVB_ASSERT_NOW(a_rt_flag, done_o && rt_zero, degenerate_o, "zero right unflagged")

endmodule

bind look_at_view_basis_top lavb_checker u_lavb_checker (.*);
